// File: sv/sha256mh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SHA-256 message hasher.
// No dependencies.
package sha256mh_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FRD   = 6'b010000,
    S_FWR   = 6'b100000
  } state_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic       shift_w;
    logic       shift_v;
    logic       round;
    logic [5:0] t;
  } round_ctrl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [3:0] LEN_WORD_HI = 4'd14;
  localparam logic [3:0] LEN_WORD_LO = 4'd15;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    unique case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

// File: sv/sha256mh_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the SHA-256 message hasher.
// Depends on nothing but the handshake convention valid/ready.
interface sha256mh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256mh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 message hasher, top level: request sequencer and digest output.
// Depends on sha256mh_pkg, sha256mh_if, sha256mh_msg_ram, sha256mh_chain_ram,
// sha256mh_round.
//
// Usage: msg takes one request per accepted valid/ready pair: an optional
// message byte and an end-of-message mark. digest returns eight 32-bit words,
// word 0 first, last_word set on word 7, after each end-of-message request.
// A byte request is accepted in the idle state; the 64th byte of a block
// starts a compression: the schedule and chaining words are loaded from the
// memories, 64 rounds run on the single round unit, and the chaining words
// are added back one memory access at a time. End of message adds padding
// before each of one or two compressions, and the eight digest words leave
// one at a time, each held until the receiver takes it. msg.ready is low
// throughout this work. A stall on digest holds the output register and the
// sequencer. Reset empties the block buffer, zeroes the byte count and
// restores the initial hash values; the next message can start at once.
module sha256_message_hasher (
  input logic              clk,
  input logic              rst,
  sha256mh_in_if.sink      msg,
  sha256mh_out_if.source   digest
);
  import sha256mh_pkg::*;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] count;
  logic [23:0] acc;
  logic [3:0]  pw;
  logic        first, len_blk, need_pad, need_len2, final_blk;
  logic [5:0]  cnt;

  logic        out_valid;
  word_t       out_word;
  logic [2:0]  out_idx;
  logic        out_last;

  logic        acc_in;
  logic [5:0]  fill_n;
  logic        m_we;
  logic [3:0]  m_waddr;
  word_t       m_wdata, m_rdata, pad_word;
  logic [7:0]  b0, b1, b2, b3;
  logic        c_we, c_clr, c_re;
  logic [2:0]  c_addr;
  word_t       c_rdata, v0, sum;
  round_ctrl_t rc;
  logic        out_free;

  assign msg.ready = (state == S_IDLE);
  assign acc_in    = msg.valid && msg.ready;
  assign fill_n    = msg.has_byte ? fill + 6'd1 : fill;
  assign out_free  = !out_valid || digest.ready;
  assign sum       = c_rdata + v0;

  // First padding word merges pending bytes with the 0x80 marker; words 14 and 15 of a length block hold the bit length
  always_comb begin
    b0 = (fill[1:0] == 2'd0) ? PAD_BYTE : acc[23:16];
    b1 = (fill[1:0] < 2'd1) ? 8'h00 : (fill[1:0] == 2'd1) ? PAD_BYTE : acc[15:8];
    b2 = (fill[1:0] < 2'd2) ? 8'h00 : (fill[1:0] == 2'd2) ? PAD_BYTE : acc[7:0];
    b3 = (fill[1:0] == 2'd3) ? PAD_BYTE : 8'h00;
    priority if (first) begin
      pad_word = {b0, b1, b2, b3};
    end else if (len_blk && pw == LEN_WORD_HI) begin
      pad_word = count[60:29];
    end else if (len_blk && pw == LEN_WORD_LO) begin
      pad_word = {count[28:0], 3'b000};
    end else begin
      pad_word = '0;
    end
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = pw;
    m_wdata = pad_word;
    if (state == S_IDLE) begin
      m_we    = acc_in && msg.has_byte && (fill[1:0] == 2'd3);
      m_waddr = fill[5:2];
      m_wdata = {acc, msg.data_byte};
    end else if (state == S_PAD) begin
      m_we = 1'b1;
    end
  end

  always_comb begin
    c_re   = 1'b0;
    c_we   = 1'b0;
    c_clr  = 1'b0;
    c_addr = cnt[2:0];
    rc     = '{shift_w: 1'b0, shift_v: 1'b0, round: 1'b0, t: cnt};
    unique case (state)
      S_LOAD: begin
        c_re       = (cnt < 6'd8);
        rc.shift_w = (cnt != 6'd0);
        rc.shift_v = (cnt != 6'd0) && (cnt <= 6'd8);
        c_addr     = cnt[2:0];
      end
      S_ROUND: rc.round = 1'b1;
      S_FRD:   c_re = 1'b1;
      S_FWR: begin
        if (!final_blk || out_free) begin
          c_we       = !final_blk;
          c_clr      = final_blk;
          rc.shift_v = 1'b1;
        end
      end
      default: ;
    endcase
  end

  sha256mh_msg_ram u_msg (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (cnt[3:0]),
    .rdata (m_rdata)
  );

  sha256mh_chain_ram u_chain (
    .clk   (clk),
    .rst   (rst),
    .we    (c_we),
    .clr   (c_clr),
    .waddr (c_addr),
    .wdata (sum),
    .re    (c_re),
    .raddr (c_addr),
    .rdata (c_rdata)
  );

  sha256mh_round u_round (
    .clk   (clk),
    .ctrl  (rc),
    .w_in  (m_rdata),
    .v_in  (c_rdata),
    .v_out (v0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      count     <= '0;
      first     <= 1'b0;
      len_blk   <= 1'b0;
      need_pad  <= 1'b0;
      need_len2 <= 1'b0;
      final_blk <= 1'b0;
      cnt       <= '0;
      pw        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && digest.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc_in) begin
            if (msg.has_byte) begin
              unique case (fill[1:0])
                2'd0: acc[23:16] <= msg.data_byte;
                2'd1: acc[15:8]  <= msg.data_byte;
                2'd2: acc[7:0]   <= msg.data_byte;
                default: ;
              endcase
              count <= count + 64'd1;
              fill  <= fill_n;
            end
            if (msg.has_byte && fill == 6'd63) begin
              state     <= S_LOAD;
              cnt       <= '0;
              final_blk <= 1'b0;
              need_pad  <= msg.end_of_message;
            end else if (msg.end_of_message) begin
              state   <= S_PAD;
              pw      <= fill_n[5:2];
              first   <= 1'b1;
              len_blk <= (fill_n < LEN_FILL);
            end
          end
        end
        S_PAD: begin
          first <= 1'b0;
          pw    <= pw + 4'd1;
          if (pw == LEN_WORD_LO) begin
            state     <= S_LOAD;
            cnt       <= '0;
            final_blk <= len_blk;
            need_pad  <= 1'b0;
            need_len2 <= !len_blk;
          end
        end
        S_LOAD: begin
          if (cnt == 6'd16) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= S_FRD;
            cnt   <= '0;
          end
        end
        S_FRD: state <= S_FWR;
        S_FWR: begin
          if (!final_blk || out_free) begin
            if (final_blk) begin
              out_valid <= 1'b1;
              out_word  <= sum;
              out_idx   <= cnt[2:0];
              out_last  <= (cnt[2:0] == 3'd7);
            end
            cnt <= cnt + 6'd1;
            if (cnt[2:0] != 3'd7) begin
              state <= S_FRD;
            end else begin
              cnt <= '0;
              priority if (final_blk) begin
                state     <= S_IDLE;
                final_blk <= 1'b0;
                fill      <= '0;
                count     <= '0;
              end else if (need_pad) begin
                // block filled by the last byte: pad from an empty buffer
                state   <= S_PAD;
                pw      <= fill[5:2];
                first   <= 1'b1;
                len_blk <= 1'b1;
              end else if (need_len2) begin
                state   <= S_PAD;
                pw      <= '0;
                first   <= 1'b0;
                len_blk <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_idx;
  assign digest.last_word   = out_last;
endmodule

// File: sv/sha256mh_msg_ram.sv
`timescale 1ns / 1ps
// Message block memory: sixteen 32-bit words, one write and one read port.
// Depends on sha256mh_pkg.
module sha256mh_msg_ram (
  input  logic                 clk,
  input  logic                 we,
  input  logic [3:0]           waddr,
  input  sha256mh_pkg::word_t  wdata,
  input  logic [3:0]           raddr,
  output sha256mh_pkg::word_t  rdata
);
  import sha256mh_pkg::*;

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sha256mh_chain_ram.sv
`timescale 1ns / 1ps
// Chaining value memory: eight 32-bit words; an entry not yet written since
// reset or digest reads as the initial hash value. Depends on sha256mh_pkg.
module sha256mh_chain_ram (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic                 clr,
  input  logic [2:0]           waddr,
  input  sha256mh_pkg::word_t  wdata,
  input  logic                 re,
  input  logic [2:0]           raddr,
  output sha256mh_pkg::word_t  rdata
);
  import sha256mh_pkg::*;

  word_t      mem [8];
  logic [7:0] vld;
  word_t      dq;
  logic       vq;
  logic [2:0] aq;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      dq <= mem[raddr];
      aq <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vq  <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end else if (clr) begin
        vld[waddr] <= 1'b0;
      end
      if (re) begin
        vq <= vld[raddr];
      end
    end
  end

  assign rdata = vq ? dq : init_h(aq);
endmodule

// File: sv/sha256mh_round.sv
`timescale 1ns / 1ps
// Round unit: rolling schedule window and working variables a..h, one
// compression round per cycle. Depends on sha256mh_pkg.
module sha256mh_round (
  input  logic                         clk,
  input  sha256mh_pkg::round_ctrl_t    ctrl,
  input  sha256mh_pkg::word_t          w_in,
  input  sha256mh_pkg::word_t          v_in,
  output sha256mh_pkg::word_t          v_out
);
  import sha256mh_pkg::*;

  word_t w [16];
  word_t v [8];
  word_t w_new, s0w, s1w, s0v, s1v, ch, mj, t1, t2;

  always_comb begin
    s0w   = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1w   = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    w_new = w[0] + s0w + w[9] + s1w;
    s1v   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
          ^ {v[4][24:0], v[4][31:25]};
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + s1v + ch + round_k(ctrl.t) + w[0];
    s0v   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
          ^ {v[0][21:0], v[0][31:22]};
    mj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = s0v + mj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_w || ctrl.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= ctrl.round ? w_new : w_in;
    end
    if (ctrl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else if (ctrl.shift_v) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= v_in;
    end
  end

  assign v_out = v[0];
endmodule
